// ===== rtl/snd_pkg.sv =====
// Shared types and constants for the SOM neuron distance/update unit.
`timescale 1ns / 1ps
`default_nettype none
package snd_pkg;

    localparam int VECTOR_LEN_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int IDX_W           = 6;
    localparam int RATE_W          = 16;
    localparam int ACC_W           = 40;
    localparam int DIST_W          = 20;
    localparam int MAG_W           = 20;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_MEASURE = 2'd1;
    localparam logic [1:0] OP_ADJUST  = 2'd2;

    typedef enum logic [1:0] {
        K_LOAD    = 2'd0,
        K_MEASURE = 2'd1,
        K_ADJUST  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  in_range;
        logic  last;
    } cmd_ctl_t;

    localparam int CTL_W = $bits(cmd_ctl_t);

endpackage
`default_nettype wire

// ===== rtl/snd_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module snd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/snd_queue.sv =====
// Short register queue between the front and back sections.
`timescale 1ns / 1ps
`default_nettype none
module snd_queue
    import snd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next;
    logic [PW-1:0]    rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rdata   = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/snd_front.sv =====
// Front section: takes input items, classifies them, drops items with no effect.
`timescale 1ns / 1ps
`default_nettype none
module snd_front
    import snd_pkg::*;
#(
    parameter int VECTOR_LEN  = VECTOR_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int AW    = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1,
    localparam int CMD_W = CTL_W + AW + SAMPLE_BITS + RATE_W
) (
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [1:0]             op,
    input  wire logic [IDX_W-1:0]       elem_index,
    input  wire logic [SAMPLE_BITS-1:0] value,
    input  wire logic [RATE_W-1:0]      rate,
    input  wire logic                   last,
    output logic                        q_push,
    output logic      [CMD_W-1:0]       q_data,
    input  wire logic                   q_full
);

    cmd_ctl_t            ctl;
    logic                keep;
    logic [IDX_W+AW-1:0] idx_ext;
    logic [AW-1:0]       addr;

    assign idx_ext = (IDX_W + AW)'(elem_index);
    assign addr    = idx_ext[AW-1:0];

    always_comb
    begin
        ctl.in_range = (32'(elem_index) < 32'(VECTOR_LEN));
        ctl.last     = last;
        ctl.kind     = K_LOAD;
        keep         = 1'b0;
        case (op)
            OP_LOAD:
            begin
                ctl.kind = K_LOAD;
                keep     = ctl.in_range;
            end
            OP_MEASURE:
            begin
                ctl.kind = K_MEASURE;
                keep     = ctl.in_range || last;
            end
            OP_ADJUST:
            begin
                ctl.kind = K_ADJUST;
                keep     = ctl.in_range;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full   = q_full;
    assign q_push = push && !q_full && keep;
    assign q_data = {ctl, addr, value, rate};

endmodule
`default_nettype wire

// ===== rtl/snd_sqrt.sv =====
// Iterative floor square root, two radicand bits per cycle, with result register.
`timescale 1ns / 1ps
`default_nettype none
module snd_sqrt
    import snd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ACC_W-1:0]  operand,
    output logic                   ready,
    input  wire logic              pop,
    output logic                   empty,
    output logic      [DIST_W-1:0] distance
);

    logic              run_reg, run_next;
    logic              oval_reg, oval_next;
    logic [DIST_W-1:0] out_reg, out_next;
    logic [ACC_W-1:0]  n_reg, n_next;
    logic [ACC_W-1:0]  root_reg, root_next;
    logic [ACC_W-1:0]  bit_reg, bit_next;
    logic [ACC_W-1:0]  trial;

    assign trial    = root_reg + bit_reg;
    assign ready    = !run_reg;
    assign empty    = !oval_reg;
    assign distance = out_reg;

    always_comb
    begin
        run_next  = run_reg;
        oval_next = oval_reg;
        out_next  = out_reg;
        n_next    = n_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        if (pop && oval_reg)
        begin
            oval_next = 1'b0;
        end
        if (start)
        begin
            run_next  = 1'b1;
            n_next    = operand;
            root_next = '0;
            bit_next  = ACC_W'(1) << (ACC_W - 2);
        end
        else if (run_reg)
        begin
            if (bit_reg != '0)
            begin
                bit_next = bit_reg >> 2;
                if (n_reg >= trial)
                begin
                    n_next    = n_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
            end
            else if (!oval_reg || pop)
            begin
                out_next  = root_reg[DIST_W-1:0];
                oval_next = 1'b1;
                run_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        n_reg    <= n_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

endmodule
`default_nettype wire

// ===== rtl/snd_back.sv =====
// Back section: weight store, distance accumulation and weight update.
`timescale 1ns / 1ps
`default_nettype none
module snd_back
    import snd_pkg::*;
#(
    parameter int VECTOR_LEN  = VECTOR_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int AW    = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1,
    localparam int CMD_W = CTL_W + AW + SAMPLE_BITS + RATE_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_empty,
    input  wire logic [CMD_W-1:0] q_data,
    output logic                  q_pop,
    input  wire logic             sq_ready,
    output logic                  sq_start,
    output logic      [ACC_W-1:0] sq_operand
);

    localparam int S = SAMPLE_BITS;

    typedef enum logic [1:0] {
        ST_ISSUE = 2'b01,
        ST_EXEC  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg;
    logic [ACC_W-1:0] acc_reg, acc_next;

    cmd_ctl_t         h_ctl, e_ctl;
    logic [AW-1:0]    h_addr, e_addr;
    logic [S-1:0]     h_value;
    logic signed [S-1:0]      e_value;
    logic        [RATE_W-1:0] e_rate;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [S-1:0]     wdata;
    logic [S-1:0]     rdata;

    logic signed [S-1:0]      w;
    logic signed [S:0]        diff;
    logic        [S:0]        mag;
    logic        [63:0]       mag_ext;
    logic                     big;
    logic        [MAG_W-1:0]  m;
    logic        [ACC_W-1:0]  sq;
    logic        [ACC_W:0]    sum;
    logic        [ACC_W-1:0]  acc_add;
    logic signed [S+17:0]     prod;
    logic signed [S+1:0]      delta;
    logic signed [S+1:0]      upd;
    logic        [S-1:0]      upd_sat;

    assign h_ctl   = q_data[CMD_W-1 -: CTL_W];
    assign h_addr  = q_data[CMD_W-CTL_W-1 -: AW];
    assign h_value = q_data[RATE_W +: S];
    assign e_ctl   = cmd_reg[CMD_W-1 -: CTL_W];
    assign e_addr  = cmd_reg[CMD_W-CTL_W-1 -: AW];
    assign e_value = cmd_reg[RATE_W +: S];
    assign e_rate  = cmd_reg[RATE_W-1:0];

    snd_ram #(
        .WIDTH (S),
        .DEPTH (VECTOR_LEN)
    ) u_weights (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (h_addr),
        .rdata (rdata)
    );

    // squared difference with saturating accumulate
    assign w       = rdata;
    assign diff    = (S+1)'(e_value) - (S+1)'(w);
    assign mag     = diff[S] ? -diff : diff;
    assign mag_ext = 64'(mag);
    assign big     = |mag_ext[63:MAG_W];
    assign m       = mag_ext[MAG_W-1:0];
    assign sq      = ACC_W'(m) * ACC_W'(m);
    assign sum     = {1'b0, acc_reg} + {1'b0, sq};
    always_comb
    begin
        if (!e_ctl.in_range)
        begin
            acc_add = acc_reg;
        end
        else if (big || sum[ACC_W])
        begin
            acc_add = '1;
        end
        else
        begin
            acc_add = sum[ACC_W-1:0];
        end
    end

    // w + floor(rate * (x - w) / 2^16), saturated
    assign prod  = $signed({1'b0, e_rate}) * diff;
    assign delta = prod[S+17:16];
    assign upd   = (S+2)'(w) + delta;
    always_comb
    begin
        if (upd[S+1:S-1] == 3'b000 || upd[S+1:S-1] == 3'b111)
        begin
            upd_sat = upd[S-1:0];
        end
        else if (upd[S+1])
        begin
            upd_sat = {1'b1, {(S-1){1'b0}}};
        end
        else
        begin
            upd_sat = {1'b0, {(S-1){1'b1}}};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        q_pop      = 1'b0;
        we         = 1'b0;
        waddr      = h_addr;
        wdata      = h_value;
        sq_start   = 1'b0;
        sq_operand = acc_add;
        case (state_reg)
            ST_ISSUE:
            begin
                if (!q_empty)
                begin
                    case (h_ctl.kind)
                        K_LOAD:
                        begin
                            q_pop = 1'b1;
                            we    = h_ctl.in_range;
                        end
                        K_MEASURE:
                        begin
                            if (!h_ctl.last || sq_ready)
                            begin
                                q_pop      = 1'b1;
                                state_next = ST_EXEC;
                            end
                        end
                        K_ADJUST:
                        begin
                            q_pop      = 1'b1;
                            state_next = ST_EXEC;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                state_next = ST_ISSUE;
                waddr      = e_addr;
                wdata      = upd_sat;
                case (e_ctl.kind)
                    K_MEASURE:
                    begin
                        if (e_ctl.last)
                        begin
                            sq_start = 1'b1;
                            acc_next = '0;
                        end
                        else
                        begin
                            acc_next = acc_add;
                        end
                    end
                    K_ADJUST:
                    begin
                        we = e_ctl.in_range;
                    end
                    default:
                    begin
                        we = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_ISSUE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ISSUE;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/som_neuron_distance_update_unit.sv =====
// Top level of the SOM neuron distance/update unit.
// Load: written in issue. Measure/adjust: weight RAM read in issue, compute in exec.
// Loads: one item per cycle; the back takes no new item while in exec (measure/adjust).
// Distance: registered on the outputs by the square root that the last measure's exec starts.
// Reset clears queue, control, and accumulator; weights are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module som_neuron_distance_update_unit
    import snd_pkg::*;
#(
    parameter int VECTOR_LEN  = VECTOR_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int AW    = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1,
    localparam int CMD_W = CTL_W + AW + SAMPLE_BITS + RATE_W
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [1:0]             op,
    input  wire logic [IDX_W-1:0]       elem_index,
    input  wire logic [SAMPLE_BITS-1:0] value,
    input  wire logic [RATE_W-1:0]      rate,
    input  wire logic                   last,
    output logic                        empty,
    input  wire logic                   pop,
    output logic      [DIST_W-1:0]      distance
);

    logic             q_push, q_full, q_pop, q_empty;
    logic [CMD_W-1:0] q_wdata, q_rdata;
    logic             sq_ready, sq_start;
    logic [ACC_W-1:0] sq_operand;

    snd_front #(
        .VECTOR_LEN  (VECTOR_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .push       (push),
        .full       (full),
        .op         (op),
        .elem_index (elem_index),
        .value      (value),
        .rate       (rate),
        .last       (last),
        .q_push     (q_push),
        .q_data     (q_wdata),
        .q_full     (q_full)
    );

    snd_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    snd_back #(
        .VECTOR_LEN  (VECTOR_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .sq_ready   (sq_ready),
        .sq_start   (sq_start),
        .sq_operand (sq_operand)
    );

    snd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .operand  (sq_operand),
        .ready    (sq_ready),
        .pop      (pop),
        .empty    (empty),
        .distance (distance)
    );

endmodule
`default_nettype wire
